// ===== design/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; users supply i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== design/rrts_pkg.sv =====
// Shared types and constants of the round-robin thread scheduler.
// No dependencies.
package rrts_pkg;

    localparam int ID_W       = 32;
    localparam int ADDR_W     = 64;
    localparam int RUN_SLOT_W = 2;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_YIELD  = 2'd1,
        CMD_EXIT   = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_HALT = 2'd2
    } t_stat;

    // Search results from the slot picker
    typedef struct packed {
        logic free_found;
        logic run_found;
    } t_pick_flags;

    // Context memory access controls
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

// ===== design/rrts_pick.sv =====
// Slot picker: first free slot and round-robin next runnable slot.
// Depends on rrts_pkg.
module rrts_pick #(
    parameter int SLOTS = 4,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic [SLOTS-1:0]     i_free,
    input  logic [SLOTS-1:0]     i_rdy,
    input  logic [IW-1:0]        i_cur,
    input  logic                 i_yield,
    output logic [IW-1:0]        o_free_idx,
    output logic [IW-1:0]        o_run_idx,
    output rrts_pkg::t_pick_flags o_flags
);
    import rrts_pkg::*;

    logic [SLOTS-1:0] cur_oh;
    logic [SLOTS-1:0] eff;
    logic [SLOTS-1:0] above;
    logic [SLOTS-1:0] sel;
    logic [SLOTS-1:0] run_oh;
    logic [SLOTS-1:0] free_oh;

    // A yielding thread competes too, but only after every other slot
    assign cur_oh = {{(SLOTS-1){1'b0}}, 1'b1} << i_cur;
    assign eff    = i_rdy | (i_yield ? cur_oh : '0);
    assign above  = eff & (({SLOTS{1'b1}} << i_cur) << 1);
    assign sel    = (|above) ? above : eff;

    // Isolate lowest set bit
    assign run_oh  = sel & (~sel + SLOTS'(1));
    assign free_oh = i_free & (~i_free + SLOTS'(1));

    // One-hot to index
    always_comb begin
        o_free_idx = '0;
        o_run_idx  = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (free_oh[k]) o_free_idx = o_free_idx | IW'(k);
            if (run_oh[k])  o_run_idx  = o_run_idx | IW'(k);
        end
    end

    assign o_flags.free_found = |i_free;
    assign o_flags.run_found  = |eff;

endmodule

// ===== design/rrts_ctx_mem.sv =====
// Per-slot context store: thread id and entry address, registered read.
// Depends on rrts_pkg.
module rrts_ctx_mem #(
    parameter int SLOTS = 4,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rrts_pkg::t_mem_ctl       i_ctl,
    input  logic [IW-1:0]            i_wr_addr,
    input  logic [rrts_pkg::ID_W-1:0]   i_wr_id,
    input  logic [rrts_pkg::ADDR_W-1:0] i_wr_entry,
    input  logic [IW-1:0]            i_rd_addr,
    output logic [rrts_pkg::ID_W-1:0]   o_rd_id,
    output logic [rrts_pkg::ADDR_W-1:0] o_rd_entry
);
    import rrts_pkg::*;

    logic [ID_W+ADDR_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]       r_vld;
    logic [ID_W+ADDR_W-1:0] r_rd_data;
    logic                   r_rd_vld;

    // Storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_wr_addr] <= {i_wr_id, i_wr_entry};
        end
        if (i_ctl.re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Written flags: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.we) r_vld[i_wr_addr] <= 1'b1;
            if (i_ctl.re) r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_id    = r_rd_vld ? r_rd_data[ID_W+ADDR_W-1:ADDR_W] : '0;
    assign o_rd_entry = r_rd_vld ? r_rd_data[ADDR_W-1:0] : '0;

endmodule

// ===== design/round_robin_thread_scheduler_core.sv =====
// Round-robin thread scheduler, top level: command sequencer and slot state.
// Depends on rrts_pkg, rrts_pick, rrts_ctx_mem and assert_macros.svh.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  command   | start / busy           | i_cmd, i_entry_addr
//  result    | o_done (1-cycle pulse) | o_status, o_new_id, o_run_slot,
//            |                        | o_run_id, o_run_entry, o_switched
//
// Each item goes through S_PICK, which picks slots and updates state while the context
// memory is read, then S_OUT, where the registered read data appears with o_done.
// busy is high only in the pick cycle; a new item may be taken while o_done shows.
// Synchronous active-low reset: slot 0 running, all others free, next id one.
// The result side cannot stall; o_done is never held off.
module round_robin_thread_scheduler_core #(
    parameter int SLOTS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_cmd,
    input  logic [rrts_pkg::ADDR_W-1:0] i_entry_addr,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [rrts_pkg::ID_W-1:0]   o_new_id,
    output logic [rrts_pkg::RUN_SLOT_W-1:0] o_run_slot,
    output logic [rrts_pkg::ID_W-1:0]   o_run_id,
    output logic [rrts_pkg::ADDR_W-1:0] o_run_entry,
    output logic                        o_switched
);
    import rrts_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_OUT
    } t_state;

    t_state            r_state,   n_state;
    t_cmd              r_cmd,     n_cmd;
    logic [ADDR_W-1:0] r_entry,   n_entry;
    logic [SLOTS-1:0]  r_free,    n_free;
    logic [SLOTS-1:0]  r_rdy,     n_rdy;
    logic [IW-1:0]     r_cur,     n_cur;
    logic [ID_W-1:0]   r_next_id, n_next_id;
    logic              r_halt,    n_halt;
    t_stat             r_status,  n_status;
    logic [ID_W-1:0]   r_new_id,  n_new_id;
    logic              r_sw,      n_sw;
    logic              r_zero,    n_zero;

    logic [IW-1:0]     free_idx;
    logic [IW-1:0]     run_idx;
    t_pick_flags       flags;
    t_mem_ctl          mem_ctl;
    logic [IW-1:0]     rd_addr;
    logic [ID_W-1:0]   rd_id;
    logic [ADDR_W-1:0] rd_entry;

    rrts_pick #(.SLOTS(SLOTS), .IW(IW)) u_pick (
        .i_free     (r_free),
        .i_rdy      (r_rdy),
        .i_cur      (r_cur),
        .i_yield    (r_cmd == CMD_YIELD),
        .o_free_idx (free_idx),
        .o_run_idx  (run_idx),
        .o_flags    (flags)
    );

    rrts_ctx_mem #(.SLOTS(SLOTS), .IW(IW)) u_ctx_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_wr_addr  (free_idx),
        .i_wr_id    (r_next_id),
        .i_wr_entry (r_entry),
        .i_rd_addr  (rd_addr),
        .o_rd_id    (rd_id),
        .o_rd_entry (rd_entry)
    );

    // Command sequencing and slot state update
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_entry   = r_entry;
        n_free    = r_free;
        n_rdy     = r_rdy;
        n_cur     = r_cur;
        n_next_id = r_next_id;
        n_halt    = r_halt;
        n_status  = r_status;
        n_new_id  = r_new_id;
        n_sw      = r_sw;
        n_zero    = r_zero;
        mem_ctl   = '0;
        rd_addr   = r_cur;
        case (r_state)
            S_IDLE, S_OUT: begin
                if (start) begin
                    n_state = S_PICK;
                    n_cmd   = t_cmd'(i_cmd);
                    n_entry = i_entry_addr;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PICK: begin
                n_state  = S_OUT;
                n_status = STAT_OK;
                n_new_id = '0;
                n_sw     = 1'b0;
                n_zero   = 1'b0;
                if (r_halt) begin
                    n_status = STAT_HALT;
                    n_zero   = 1'b1;
                end else begin
                    case (r_cmd)
                        CMD_CREATE: begin
                            mem_ctl.re = 1'b1;
                            if (flags.free_found) begin
                                mem_ctl.we        = 1'b1;
                                n_free[free_idx]  = 1'b0;
                                n_rdy[free_idx]   = 1'b1;
                                n_new_id          = r_next_id;
                                n_next_id         = r_next_id + ID_W'(1);
                            end else begin
                                n_status = STAT_FULL;
                            end
                        end
                        CMD_YIELD, CMD_EXIT: begin
                            if (flags.run_found) begin
                                // release current first, then claim the pick
                                if (r_cmd == CMD_YIELD) n_rdy[r_cur] = 1'b1;
                                else                   n_free[r_cur] = 1'b1;
                                n_rdy[run_idx] = 1'b0;
                                n_cur          = run_idx;
                                n_sw           = (run_idx != r_cur);
                                rd_addr        = run_idx;
                                mem_ctl.re     = 1'b1;
                            end else begin
                                n_halt   = 1'b1;
                                n_status = STAT_HALT;
                                n_zero   = 1'b1;
                            end
                        end
                        default: begin
                            mem_ctl.re = 1'b1;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= {{(SLOTS-1){1'b1}}, 1'b0};
            r_rdy     <= '0;
            r_cur     <= '0;
            r_next_id <= ID_W'(1);
            r_halt    <= 1'b0;
            r_status  <= STAT_OK;
            r_new_id  <= '0;
            r_sw      <= 1'b0;
            r_zero    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_rdy     <= n_rdy;
            r_cur     <= n_cur;
            r_next_id <= n_next_id;
            r_halt    <= n_halt;
            r_status  <= n_status;
            r_new_id  <= n_new_id;
            r_sw      <= n_sw;
            r_zero    <= n_zero;
        end
    end

    // Command payload, no reset
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_entry <= n_entry;
    end

    // Result ports
    assign busy        = (r_state == S_PICK);
    assign o_done      = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_new_id    = r_new_id;
    assign o_run_slot  = r_zero ? '0 : RUN_SLOT_W'(r_cur);
    assign o_run_id    = r_zero ? '0 : rd_id;
    assign o_run_entry = r_zero ? '0 : rd_entry;
    assign o_switched  = r_sw;

    // Checks
    `ASSERT_NEXT(a_pick_then_done, r_state == S_PICK, o_done)
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ASSERT_IMPLIES(a_cur_running, !r_halt, !r_free[r_cur] && !r_rdy[r_cur])
    `ASSERT_IMPLIES(a_free_rdy_disjoint, 1'b1, (r_free & r_rdy) == '0)
    `ASSERT_IMPLIES(a_halt_blank, o_done && o_status == STAT_HALT,
                    o_run_id == '0 && o_run_entry == '0 && !o_switched)

endmodule
